// ===== sv/oll_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Holds the action and status codes, the cell command type and the controller state type.
// No dependencies.
package oll_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int ACT_W        = 3;
  localparam int ST_W         = 2;

  // Action codes on the action port.
  localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_HEAD = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_KEY  = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     found;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_t;

endpackage

// ===== sv/oll_cell.sv =====
// One storage cell of the ordered list row.
// Holds one entry and trades it with its left and right neighbors on command.
// Depends on oll_pkg.
module oll_cell
  import oll_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [IDX_W-1:0]         idx,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     hit
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic at_idx;
  logic key_eq;

  assign at_idx = (MY_IDX == idx);
  assign key_eq = (data == key);
  assign hit    = (ctl.op == CELL_SCAN) && at_idx && key_eq;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INSERT: begin
        // open the gap: cells past the insert point move one step toward the tail
        if (MY_IDX > idx) begin
          data <= left_data;
        end else if (at_idx) begin
          data <= key;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= idx) begin
          data <= right_data;
        end
      end
      CELL_SCAN: begin
        // close the gap as the scan passes, once the key has been seen
        if (at_idx && (ctl.found || key_eq)) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/ordered_list_engine_top.sv =====
// Top level of the ordered list engine: controller plus the row of list cells.
// Depends on oll_pkg and oll_cell.
//
// The engine keeps up to CAPACITY signed 32-bit entries in order, cell 0 being the head.
// Pulse start with an action while busy is low to transfer one command; busy rises the next
// cycle and stays high until the result has been shown. Every command yields exactly one
// result, present on status, length_after and head_value for the single cycle in which
// done is high; the receiver cannot stall it, so capture it in that cycle. Inserts and
// delete-head shift all cells in parallel when the command is taken, then show the result.
// Delete-by-key on a non-empty list walks a scan pointer along the row, one cell per cycle,
// closing the gap behind the first match, then shows the result. Inserts into a full list
// report "list full", deletes on an empty list report "list empty", a missing key reports
// "key not found"; the list is left unchanged in all three cases. Unused action codes only
// report.
module ordered_list_engine_top
  import oll_pkg::*;
#(
  parameter int  CAPACITY = CAPACITY_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] value,
  input  logic [CNT_W-1:0]         position,
  output logic                     done,
  output logic [ST_W-1:0]          status,
  output logic [CNT_W-1:0]         length_after,
  output logic signed [DATA_W-1:0] head_value
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Controller registers
  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         scan_idx, scan_idx_next;
  logic                     found, found_next;
  logic signed [DATA_W-1:0] key, key_next;
  status_t                  st, st_next;

  // Row broadcast
  cell_ctl_t                cell_ctl;
  logic [IDX_W-1:0]         cell_idx;
  logic signed [DATA_W-1:0] cell_key;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_hit;

  logic             accept;
  logic             not_full;
  logic             is_empty;
  logic             scan_last;
  logic             hit_any;
  logic             found_now;
  logic [IDX_W-1:0] ins_pos;

  assign accept    = start && (state == S_IDLE);
  assign not_full  = (count != CAP_CNT);
  assign is_empty  = (count == '0);
  assign hit_any   = |cell_hit;
  assign found_now = found || hit_any;
  assign scan_last = (CNT_W'(scan_idx) == (count - ONE_CNT));
  // Clamp a position past the end to the tail. Truncation is safe: an insert is only
  // carried out when the list is not full, so the index stays below CAPACITY.
  assign ins_pos   = (position < count) ? position[IDX_W-1:0] : count[IDX_W-1:0];

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((action == ACT_DEL_KEY) && !is_empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_REPORT;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    count_next    = count;
    scan_idx_next = scan_idx;
    found_next    = found;
    key_next      = key;
    st_next       = st;
    cell_ctl.op   = CELL_HOLD;
    cell_ctl.found = found;
    cell_idx      = '0;
    cell_key      = value;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          st_next = ST_DONE;
          unique case (action)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
              if (not_full) begin
                cell_ctl.op = CELL_INSERT;
                count_next  = count + ONE_CNT;
                if (action == ACT_INS_HEAD) begin
                  cell_idx = '0;
                end else if (action == ACT_INS_TAIL) begin
                  cell_idx = count[IDX_W-1:0];
                end else begin
                  cell_idx = ins_pos;
                end
              end else begin
                st_next = ST_FULL;
              end
            end
            ACT_DEL_HEAD: begin
              if (is_empty) begin
                st_next = ST_EMPTY;
              end else begin
                cell_ctl.op = CELL_REMOVE;
                cell_idx    = '0;
                count_next  = count - ONE_CNT;
              end
            end
            ACT_DEL_KEY: begin
              if (is_empty) begin
                st_next = ST_EMPTY;
              end else begin
                // latch the key and park the scan pointer at the head
                key_next      = value;
                scan_idx_next = '0;
                found_next    = 1'b0;
              end
            end
            default: begin
              st_next = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cell_ctl.op = CELL_SCAN;
        cell_idx    = scan_idx;
        cell_key    = key;
        if (scan_last) begin
          st_next = found_now ? ST_DONE : ST_NOT_FOUND;
          if (found_now) begin
            count_next = count - ONE_CNT;
          end
        end else begin
          // advance the pointer one cell toward the tail
          scan_idx_next = scan_idx + IDX_W'(1);
          found_next    = found_now;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      found <= 1'b0;
      st    <= ST_DONE;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
      st    <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    key      <= key_next;
  end

  // Row of cells; each trades data with its neighbors
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (gi == 0) begin : g_head
      assign left_d = cell_key;
    end else begin : g_mid_l
      assign left_d = cell_data[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_tail
      assign right_d = cell_data[gi];
    end else begin : g_mid_r
      assign right_d = cell_data[gi+1];
    end

    oll_cell #(
      .IDX_W (IDX_W),
      .INDEX (gi)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .idx        (cell_idx),
      .key        (cell_key),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[gi]),
      .hit        (cell_hit[gi])
    );
  end

  // Result: one cycle in S_REPORT, reading the updated row
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_REPORT);
  assign status       = st;
  assign length_after = count;
  assign head_value   = is_empty ? '0 : cell_data[0];

endmodule

// ===== tb/sv/tb_ordered_list_engine_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ordered_list_engine_top: directed and random command transfers
// against a queue-based prediction of the list. Depends on oll_pkg and ordered_list_engine_top.
module tb_ordered_list_engine_top;
  import oll_pkg::*;

  localparam int LEN_W        = $clog2(CAPACITY_DEF + 1);
  localparam int RANDOM_CMDS  = 1300;
  localparam int PHASE_LEN    = 130;
  localparam int DRAIN_CYCLES = CAPACITY_DEF + 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] val;
    logic [LEN_W-1:0]         pos;
  } list_cmd_t;

  typedef struct packed {
    status_t                  st;
    logic [LEN_W-1:0]         len;
    logic signed [DATA_W-1:0] head;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [ACT_W-1:0]         action = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic [LEN_W-1:0]         position = '0;
  logic                     busy;
  logic                     done;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length_after;
  logic signed [DATA_W-1:0] head_value;

  list_cmd_t                pending_cmds[$];
  list_result_t             expected_results[$];
  logic signed [DATA_W-1:0] shadow_list[$];
  logic signed [DATA_W-1:0] value_pool[16];

  int          error_count = 0;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  logic        xfer_q      = 1'b0;

  ordered_list_engine_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .value        (value),
    .position     (position),
    .done         (done),
    .status       (status),
    .length_after (length_after),
    .head_value   (head_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the engine hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Apply one command to the shadow list and return the result the engine must report.
  // Cell 0 of the engine is the front of the queue.
  function automatic list_result_t predict_list_update(input list_cmd_t cmd);
    list_result_t r;
    int idx;
    int hit;
    r.st = ST_DONE;
    hit = -1;
    case (cmd.act)
      ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
        if (shadow_list.size() >= CAPACITY_DEF) begin
          r.st = ST_FULL;
        end else begin
          if (cmd.act == ACT_INS_HEAD)
            idx = 0;
          else if (cmd.act == ACT_INS_TAIL)
            idx = shadow_list.size();
          else
            idx = (int'(cmd.pos) < shadow_list.size()) ? int'(cmd.pos) : shadow_list.size();
          shadow_list.insert(idx, cmd.val);
        end
      end
      ACT_DEL_HEAD: begin
        if (shadow_list.size() == 0)
          r.st = ST_EMPTY;
        else
          shadow_list.delete(0);
      end
      ACT_DEL_KEY: begin
        if (shadow_list.size() == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // Only the match nearest the head goes away.
          for (int i = shadow_list.size() - 1; i >= 0; i--)
            if (shadow_list[i] == cmd.val) hit = i;
          if (hit < 0)
            r.st = ST_NOT_FOUND;
          else
            shadow_list.delete(hit);
        end
      end
      default: ;  // unused codes only report the current list
    endcase
    r.len  = LEN_W'(shadow_list.size());
    r.head = (shadow_list.size() > 0) ? shadow_list[0] : '0;
    return r;
  endfunction

  task automatic queue_cmd(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
                           input int pos);
    list_cmd_t c;
    c.act = act;
    c.val = val;
    c.pos = LEN_W'(pos);
    pending_cmds.push_back(c);
  endtask

  // Mostly draw from a small pool so keys hit and duplicates pile up.
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70)
      return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      return ACT_W'($urandom_range(5, 7));
    if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       return ACT_INS_HEAD;
        1:       return ACT_INS_TAIL;
        default: return ACT_INS_POS;
      endcase
    end
    return ($urandom_range(0, 99) < 35) ? ACT_DEL_HEAD : ACT_DEL_KEY;
  endfunction

  // Driver: hold a command until it transfers, then present the next one or idle.
  // Bursts of random length alternate with random gaps, some of them zero.
  always @(negedge clk) begin
    list_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || xfer_q) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        start    <= 1'b1;
        action   <= c.act;
        value    <= c.val;
        position <= c.pos;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
          case ($urandom_range(0, 3))
            0:       gap_left <= 0;
            1:       gap_left <= $urandom_range(1, 3);
            2:       gap_left <= $urandom_range(4, 12);
            default: gap_left <= $urandom_range(13, CAPACITY_DEF + 6);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string fname, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, fname, exp_v, act_v);
      error_count++;
    end
  endtask

  // Monitor: check the strobed result first, then record any command that transfers
  // on this edge.
  always @(posedge clk) begin
    list_result_t exp_r;
    xfer_q <= start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no command outstanding, status %0d length %0d head 0x%08h",
                   $time, status, length_after, head_value);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", DATA_W'(exp_r.st), DATA_W'(status));
          check_field("length_after", DATA_W'(exp_r.len), DATA_W'(length_after));
          check_field("head_value", exp_r.head, head_value);
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_list_update({action, value, position}));
    end
  end

  initial begin
    int ins_pct;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    // Directed: deletes on an empty list, insert at position zero, field extremes,
    // insert past the tail, a missing key, duplicate keys and the unused codes.
    queue_cmd(ACT_DEL_HEAD, 32'sd5, 0);
    queue_cmd(ACT_DEL_KEY, 32'sd5, 0);
    queue_cmd(ACT_INS_POS, 32'sd11, 0);
    queue_cmd(ACT_INS_HEAD, 32'sh8000_0000, 127);
    queue_cmd(ACT_INS_TAIL, 32'sh7fff_ffff, 0);
    queue_cmd(ACT_INS_POS, -32'sd1, 1);
    queue_cmd(ACT_INS_POS, 32'sd22, 127);
    queue_cmd(ACT_INS_POS, 32'sd33, CAPACITY_DEF);
    queue_cmd(ACT_INS_POS, 32'sd44, 4);
    queue_cmd(ACT_DEL_KEY, 32'sd99, 0);
    queue_cmd(ACT_INS_TAIL, 32'sd7, 0);
    queue_cmd(ACT_INS_HEAD, 32'sd7, 0);
    queue_cmd(ACT_DEL_KEY, 32'sd7, 0);
    queue_cmd(ACT_DEL_KEY, 32'sh7fff_ffff, 0);
    queue_cmd(ACT_DEL_KEY, 32'sh8000_0000, 0);
    queue_cmd(3'd5, 32'sd1, 1);
    queue_cmd(3'd6, -32'sd1, 127);
    queue_cmd(3'd7, 32'sd0, 64);
    queue_cmd(ACT_DEL_HEAD, 32'sd0, 0);
    queue_cmd(ACT_DEL_KEY, 32'sd7, 0);

    // Random: rotate through fill, drain and balanced phases so the list
    // swings between full and empty.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      case ((n / PHASE_LEN) % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      queue_cmd(pick_action(ins_pct), pick_value(),
                ($urandom_range(0, 99) < 80) ? $urandom_range(0, CAPACITY_DEF)
                                             : $urandom_range(0, 127));
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every command transferred, every result back, then let the engine settle.
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
